// ===== design/dhkd_pkg.sv =====
// ----------------------------------------------------------------------------
// Double hash key digest package
// Shared widths, constants and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
`default_nettype none

package dhkd_pkg;

  // Field widths.
  localparam int CHAR_W = 8;
  localparam int HASH_W = 32;
  localparam int SLOT_BITS = 16;

  // Width of the remainder iteration counter.
  localparam int CNT_W = $clog2(HASH_W);

  // Hash seeds and the reset table size.
  localparam logic [HASH_W-1:0] DJB_SEED = HASH_W'(5381);
  localparam logic [HASH_W-1:0] OAAT_SEED = '0;
  localparam logic [SLOT_BITS-1:0] TABLE_SIZE_RESET = SLOT_BITS'(1021);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic absorb;      // fold one nonzero character into both hashes
    logic terminate;   // snapshot both hashes and restart the accumulators
    logic fin_mix;     // first finalization step of the secondary hash
    logic fin_add;     // last finalization step of the secondary hash
    logic div_step;    // one restoring step of both remainders
    logic out_load;    // load the result register
  } dhkd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic char_zero;   // the character on the input ends the key
  } dhkd_sts_t;

endpackage : dhkd_pkg

`default_nettype wire

// ===== design/dhkd_ifs.sv =====
// ----------------------------------------------------------------------------
// Double hash key digest channels
// Valid/ready channels for key characters and for digest results.
// ----------------------------------------------------------------------------
`default_nettype none

// Key character channel: one word is one character byte.
interface dhkd_char_if;
  import dhkd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface : dhkd_char_if

// Digest channel: one word is the full digest of one key.
interface dhkd_digest_if;
  import dhkd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [HASH_W-1:0]    primary_hash;
  logic [HASH_W-1:0]    secondary_hash;
  logic [SLOT_BITS-1:0] home_slot;
  logic [SLOT_BITS-1:0] probe_step;

  modport source (output valid, output primary_hash, output secondary_hash,
                  output home_slot, output probe_step, input ready);
  modport sink (input valid, input primary_hash, input secondary_hash,
                input home_slot, input probe_step, output ready);
endinterface : dhkd_digest_if

`default_nettype wire

// ===== design/dhkd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Double hash key digest controller
// Sequences absorb, finalization, the serial remainder and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module dhkd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire dhkd_pkg::dhkd_sts_t sts,
  output dhkd_pkg::dhkd_cmd_t    cmd
);
  import dhkd_pkg::*;

  localparam logic [2:0] ST_ACC  = 3'd0;
  localparam logic [2:0] ST_MIX  = 3'd1;
  localparam logic [2:0] ST_ADD  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HASH_W - 1);

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             out_full;
  logic             out_full_next;

  assign in_ready  = (state == ST_ACC);
  assign out_valid = out_full;

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      ST_ACC: begin
        if (in_valid) begin
          if (sts.char_zero) begin
            cmd.terminate = 1'b1;
            state_next    = ST_MIX;
          end else begin
            cmd.absorb = 1'b1;
          end
        end
      end
      ST_MIX: begin
        cmd.fin_mix = 1'b1;
        state_next  = ST_ADD;
      end
      ST_ADD: begin
        cmd.fin_add = 1'b1;
        cnt_next    = CNT_LAST;
        state_next  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_full || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_ACC;
        end
      end
      default: begin
        state_next = ST_ACC;
      end
    endcase
  end

  // The result register is full from its load until the word is taken.
  always_comb begin
    out_full_next = out_full;
    if (out_full && out_ready) begin
      out_full_next = 1'b0;
    end
    if (cmd.out_load) begin
      out_full_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_ACC;
      cnt      <= '0;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      out_full <= out_full_next;
    end
  end

endmodule : dhkd_ctrl

`default_nettype wire

// ===== design/dhkd_dpath.sv =====
// ----------------------------------------------------------------------------
// Double hash key digest datapath
// Hash accumulators, finalization, two serial remainders and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dhkd_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          table_size_we,
  input  wire logic [dhkd_pkg::SLOT_BITS-1:0] table_size_wdata,
  input  wire logic [dhkd_pkg::CHAR_W-1:0]    char_code,
  input  wire dhkd_pkg::dhkd_cmd_t           cmd,
  output dhkd_pkg::dhkd_sts_t                sts,
  output logic [dhkd_pkg::HASH_W-1:0]         primary_hash,
  output logic [dhkd_pkg::HASH_W-1:0]         secondary_hash,
  output logic [dhkd_pkg::SLOT_BITS-1:0]      home_slot,
  output logic [dhkd_pkg::SLOT_BITS-1:0]      probe_step
);
  import dhkd_pkg::*;

  logic [SLOT_BITS-1:0] table_size;
  logic [HASH_W-1:0]    djb_acc;
  logic [HASH_W-1:0]    oaat_acc;
  logic [HASH_W-1:0]    prim;
  logic [HASH_W-1:0]    sec;
  logic [SLOT_BITS-1:0] rem_p;
  logic [SLOT_BITS-1:0] rem_s;

  logic [HASH_W-1:0]    char_ext;
  logic [HASH_W-1:0]    oaat_sum;
  logic [HASH_W-1:0]    oaat_mix;
  logic [HASH_W-1:0]    sec_mix;
  logic [SLOT_BITS:0]   cat_p;
  logic [SLOT_BITS:0]   cat_s;
  logic [SLOT_BITS+1:0] diff_p;
  logic [SLOT_BITS+1:0] diff_s;
  logic                 size_zero;

  assign sts.char_zero = (char_code == '0);
  assign size_zero     = (table_size == '0);

  // The character is a signed byte, so it is sign-extended before use.
  assign char_ext = {{(HASH_W - CHAR_W){char_code[CHAR_W-1]}}, char_code};

  // One-at-a-time character step: add, shift-add, shift-xor.
  assign oaat_sum = oaat_acc + char_ext;
  assign oaat_mix = oaat_sum + (oaat_sum << 10);

  // First part of the finalization: shift-add by three, then shift-xor.
  assign sec_mix = sec + (sec << 3);

  // One restoring step per hash: shift the next dividend bit into the remainder.
  assign cat_p  = {rem_p, prim[HASH_W-1]};
  assign cat_s  = {rem_s, sec[HASH_W-1]};
  assign diff_p = {1'b0, cat_p} - {2'b00, table_size};
  assign diff_s = {1'b0, cat_s} - {2'b00, table_size};

  // Table size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TABLE_SIZE_RESET;
    end else if (table_size_we) begin
      table_size <= table_size_wdata;
    end
  end

  // Running hashes; both restart once the key ends.
  always_ff @(posedge clk) begin
    if (rst) begin
      djb_acc  <= DJB_SEED;
      oaat_acc <= OAAT_SEED;
    end else if (cmd.terminate) begin
      djb_acc  <= DJB_SEED;
      oaat_acc <= OAAT_SEED;
    end else if (cmd.absorb) begin
      djb_acc  <= (djb_acc << 5) + djb_acc + char_ext;
      oaat_acc <= oaat_mix ^ (oaat_mix >> 6);
    end
  end

  // Snapshot, finalization and serial remainder. The dividends rotate left,
  // so after a full pass they hold the hashes again.
  always_ff @(posedge clk) begin
    if (cmd.terminate) begin
      prim  <= djb_acc;
      sec   <= oaat_acc;
      rem_p <= '0;
      rem_s <= '0;
    end else if (cmd.fin_mix) begin
      sec <= sec_mix ^ (sec_mix >> 11);
    end else if (cmd.fin_add) begin
      sec <= sec + (sec << 15);
    end else if (cmd.div_step) begin
      prim  <= {prim[HASH_W-2:0], prim[HASH_W-1]};
      sec   <= {sec[HASH_W-2:0], sec[HASH_W-1]};
      rem_p <= diff_p[SLOT_BITS+1] ? cat_p[SLOT_BITS-1:0] : diff_p[SLOT_BITS-1:0];
      rem_s <= diff_s[SLOT_BITS+1] ? cat_s[SLOT_BITS-1:0] : diff_s[SLOT_BITS-1:0];
    end
  end

  // Result register. A zero table size acts as a single slot, and a zero
  // probe step is replaced by one.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      primary_hash   <= prim;
      secondary_hash <= sec;
      home_slot      <= size_zero ? '0 : rem_p;
      probe_step     <= (size_zero || (rem_s == '0)) ? SLOT_BITS'(1) : rem_s;
    end
  end

endmodule : dhkd_dpath

`default_nettype wire

// ===== design/double_hash_key_digest_unit.sv =====
// ----------------------------------------------------------------------------
// Double hash key digest unit
// Hashes a key with DJB2 and one-at-a-time and gives home slot and probe step.
// ----------------------------------------------------------------------------
// A key arrives one character per word. A zero character ends the key; the
// block then finalizes the secondary hash with a mix step and an add step,
// runs a bit-serial restoring remainder unit that computes both moduli side
// by side, and loads the result register once it is free; only then is the
// next character taken. The digest waits in its output register while the
// next key streams in. Table size 0 acts as one slot. Write the table size
// only while the block is idle.
`default_nettype none

module double_hash_key_digest_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          table_size_we,
  input  wire logic [dhkd_pkg::SLOT_BITS-1:0] table_size_wdata,
  dhkd_char_if.sink                          chars,
  dhkd_digest_if.source                      digests
);
  import dhkd_pkg::*;

  dhkd_cmd_t cmd;
  dhkd_sts_t sts;

  // Sequencing and handshakes.
  dhkd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chars.valid),
    .in_ready  (chars.ready),
    .out_valid (digests.valid),
    .out_ready (digests.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hashing, remainders and the result register.
  dhkd_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .table_size_we    (table_size_we),
    .table_size_wdata (table_size_wdata),
    .char_code        (chars.char_code),
    .cmd              (cmd),
    .sts              (sts),
    .primary_hash     (digests.primary_hash),
    .secondary_hash   (digests.secondary_hash),
    .home_slot        (digests.home_slot),
    .probe_step       (digests.probe_step)
  );

endmodule : double_hash_key_digest_unit

`default_nettype wire
